>>> hw/rtl/tds_pkg.sv
// Shared types and constants for the transfer distance search block.
package tds_pkg;

  localparam int unsigned IDX_W   = 9;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned P_W     = 8;
  localparam int unsigned ONES_W  = 16;
  localparam int unsigned EPOCH_W = 8;
  localparam int unsigned DIST_W  = 20;
  localparam int unsigned MIN_W   = 8;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [IDX_W-1:0]  node_index;
    logic [IDX_W-1:0]  left_child;
    logic [IDX_W-1:0]  right_child;
    logic [SIZE_W-1:0] leaves_below;
    logic [P_W-1:0]    light_size;
    logic [IDX_W-1:0]  first_leaf;
    logic [IDX_W-1:0]  last_leaf;
    logic              side_bit;
  } tds_in_t;

  typedef struct packed {
    logic [MIN_W-1:0] min_distance;
    logic             stopped_early;
  } tds_out_t;

endpackage

>>> hw/rtl/tds_if.sv
// Valid/ready channels carrying command and result words.
interface tds_in_if;
  logic             valid;
  logic             ready;
  tds_pkg::tds_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tds_out_if;
  logic              valid;
  logic              ready;
  tds_pkg::tds_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/transfer_distance_search_top.sv
// Transfer distance search: postorder table, per-query count walk and minimum.
// Clear and load words are taken in ST_IDLE. A query walks the table one entry per cycle
// through the scratch memory, stopping early on a distance of 1, and its result is
// registered in ST_DONE. The next word waits until the result can be sent.
// Reset clears the entry count, sets leaf_total to 256 and runs a clearing pass over every
// scratch memory slot, repeated after every 255th query; no word is taken then.
module transfer_distance_search_top #(
  parameter int unsigned MAX_TIPS   = 256,
  parameter int unsigned NODE_SLOTS = 512
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tds_pkg::IDX_W-1:0]  cfg_data_i,
  tds_in_if.sink                     in_i,
  tds_out_if.source                  out_o
);
  import tds_pkg::*;

  localparam int unsigned TIP_AW  = (MAX_TIPS > 1) ? $clog2(MAX_TIPS) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_TIPS + 1);
  localparam int unsigned SLOT_AW = $clog2(NODE_SLOTS);
  localparam int unsigned WIDE_W  = SLOT_AW + IDX_W;
  localparam int unsigned SCR_W   = EPOCH_W + ONES_W;
  localparam logic [WIDE_W-1:0]  SlotsW   = WIDE_W'(NODE_SLOTS);
  localparam logic [CNT_W-1:0]   TipsFull = CNT_W'(MAX_TIPS);
  localparam logic [SLOT_AW-1:0] SlotLast = SLOT_AW'(NODE_SLOTS - 1);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_WALK, ST_DONE} state_e;

  function automatic logic [SLOT_AW-1:0] slot_addr(logic [IDX_W-1:0] idx);
    logic [WIDE_W-1:0] w;
    w = {{SLOT_AW{1'b0}}, idx};
    return w[SLOT_AW-1:0];
  endfunction

  function automatic logic slot_ok(logic [IDX_W-1:0] idx);
    logic [WIDE_W-1:0] w;
    w = {{SLOT_AW{1'b0}}, idx};
    return w < SlotsW;
  endfunction

  // storage
  logic [3*IDX_W-1:0] tbl_mem  [MAX_TIPS];
  logic [SIZE_W-1:0]  size_mem [NODE_SLOTS];
  logic [SCR_W-1:0]   scr_mem  [NODE_SLOTS];

  // control
  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   iss_q;
  logic [SLOT_AW-1:0] clr_q;
  logic [EPOCH_W-1:0] epoch_q;
  logic [IDX_W-1:0]   leaf_total_q;
  logic               s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic               wr_vld_q;
  logic               early_q;
  logic [MIN_W-1:0]   best_q;
  logic               out_vld_q;

  // query operands and pipeline payload
  logic [P_W-1:0]     p_q;
  logic [IDX_W-1:0]   lo_q, hi_q;
  logic               side_q;
  logic [3*IDX_W-1:0] tbl_rd_q;
  logic [SCR_W-1:0]   scr_l_q, scr_r_q;
  logic [SIZE_W-1:0]  size_rd_q;
  logic [IDX_W-1:0]   s2_node_q, s2_left_q, s2_right_q;
  logic [SLOT_AW-1:0] wr_addr_q;
  logic [ONES_W-1:0]  wr_val_q;
  logic [ONES_W-1:0]  ones_q;
  logic [SIZE_W-1:0]  size_q;
  logic [DIST_W-1:0]  cand_q;
  tds_out_t           out_q;

  logic               in_acc, issue, ld_ok, walk_end, emit;
  logic [IDX_W-1:0]   s1_node, s1_left, s1_right;
  logic [ONES_W-1:0]  cnt_l, cnt_r, ones_d;
  logic               wr_en;
  logic [DIST_W-1:0]  d_u, alt_u, cand_d;
  logic [IDX_W-1:0]   half;
  logic               take, hit_one;

  function automatic logic [ONES_W-1:0] slot_count(
    logic [IDX_W-1:0] idx, logic [SCR_W-1:0] rd, logic fwd_vld,
    logic [SLOT_AW-1:0] fwd_addr, logic [ONES_W-1:0] fwd_val,
    logic [EPOCH_W-1:0] ep, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi, logic side);
    logic inr;
    inr = (idx >= lo) && (idx <= hi);
    if (!slot_ok(idx)) return '0;
    else if (fwd_vld && fwd_addr == slot_addr(idx)) return fwd_val;
    else if (rd[SCR_W-1:ONES_W] == ep) return rd[ONES_W-1:0];
    else return {{(ONES_W-1){1'b0}}, inr ? side : ~side};
  endfunction

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign ld_ok       = in_acc && (in_i.data.action == ACT_LOAD) && (cnt_q != TipsFull);
  assign issue       = (state_q == ST_WALK) && (iss_q < cnt_q) && !hit_one;
  assign walk_end    = (state_q == ST_WALK) && (iss_q == cnt_q) &&
                       !s1_vld_q && !s2_vld_q && !s3_vld_q && !s4_vld_q;
  assign emit        = (state_q == ST_DONE) && (!out_vld_q || out_o.ready);

  assign {s1_node, s1_left, s1_right} = tbl_rd_q;

  always_comb begin
    cnt_l  = slot_count(s2_left_q, scr_l_q, wr_vld_q, wr_addr_q, wr_val_q,
                        epoch_q, lo_q, hi_q, side_q);
    cnt_r  = slot_count(s2_right_q, scr_r_q, wr_vld_q, wr_addr_q, wr_val_q,
                        epoch_q, lo_q, hi_q, side_q);
    ones_d = cnt_l + cnt_r;
    wr_en  = s2_vld_q && slot_ok(s2_node_q);
  end

  always_comb begin
    half   = leaf_total_q >> 1;
    d_u    = DIST_W'(p_q) - DIST_W'(size_q) + (DIST_W'(ones_q) << 1);
    alt_u  = DIST_W'(leaf_total_q) - d_u;
    cand_d = (d_u[DIST_W-1] || d_u > DIST_W'(half)) ? alt_u : d_u;
    take   = s4_vld_q && !cand_q[DIST_W-1] && (cand_q < DIST_W'(best_q));
    hit_one = take && (cand_q == DIST_W'(1));
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (ld_ok) begin
      tbl_mem[cnt_q[TIP_AW-1:0]] <= {in_i.data.node_index, in_i.data.left_child,
                                     in_i.data.right_child};
      if (slot_ok(in_i.data.node_index)) begin
        size_mem[slot_addr(in_i.data.node_index)] <= in_i.data.leaves_below;
      end
    end
    if (state_q == ST_CLEAR) begin
      scr_mem[clr_q] <= '0;
    end else if (wr_en) begin
      scr_mem[slot_addr(s2_node_q)] <= {epoch_q, ones_d};
    end
    tbl_rd_q  <= tbl_mem[iss_q[TIP_AW-1:0]];
    scr_l_q   <= scr_mem[slot_addr(s1_left)];
    scr_r_q   <= scr_mem[slot_addr(s1_right)];
    size_rd_q <= size_mem[slot_addr(s1_node)];
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.data.action == ACT_QUERY) begin
      p_q    <= in_i.data.light_size;
      lo_q   <= in_i.data.first_leaf;
      hi_q   <= in_i.data.last_leaf;
      side_q <= in_i.data.side_bit;
    end
    s2_node_q  <= s1_node;
    s2_left_q  <= s1_left;
    s2_right_q <= s1_right;
    wr_addr_q  <= slot_addr(s2_node_q);
    wr_val_q   <= ones_d;
    ones_q     <= ones_d;
    size_q     <= slot_ok(s2_node_q) ? size_rd_q : '0;
    cand_q     <= cand_d;
    if (emit) begin
      out_q.min_distance  <= best_q;
      out_q.stopped_early <= early_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      iss_q        <= '0;
      clr_q        <= '0;
      epoch_q      <= '0;
      leaf_total_q <= IDX_W'(256);
      s1_vld_q     <= 1'b0;
      s2_vld_q     <= 1'b0;
      s3_vld_q     <= 1'b0;
      s4_vld_q     <= 1'b0;
      wr_vld_q     <= 1'b0;
      early_q      <= 1'b0;
      best_q       <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) leaf_total_q <= cfg_data_i;
      wr_vld_q <= wr_en;
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q && !hit_one;
      s3_vld_q <= s2_vld_q && !hit_one;
      s4_vld_q <= s3_vld_q && !hit_one;
      if (emit) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;

      unique case (state_q)
        ST_CLEAR: begin
          if (clr_q == SlotLast) begin
            clr_q   <= '0;
            epoch_q <= EPOCH_W'(1);
            state_q <= ST_IDLE;
          end else begin
            clr_q <= clr_q + SLOT_AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_i.data.action)
              ACT_CLEAR: cnt_q <= '0;
              ACT_LOAD:  if (ld_ok) cnt_q <= cnt_q + CNT_W'(1);
              ACT_QUERY: begin
                best_q  <= (in_i.data.light_size != '0) ?
                           in_i.data.light_size - P_W'(1) : '0;
                early_q <= 1'b0;
                iss_q   <= '0;
                state_q <= ST_WALK;
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (issue) iss_q <= iss_q + CNT_W'(1);
          if (take) best_q <= cand_q[MIN_W-1:0];
          if (hit_one) begin
            early_q <= 1'b1;
            state_q <= ST_DONE;
          end else if (walk_end) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (emit) begin
            epoch_q <= epoch_q + EPOCH_W'(1);
            state_q <= (epoch_q == '1) ? ST_CLEAR : ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule

>>> tb/sv/tds_checker.sv
// Checker for the transfer distance search block: predicts each query result and compares.
module tds_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tds_pkg::IDX_W-1:0] cfg_data_i,
  tds_in_if                         word_in,
  tds_out_if                        word_out,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o,
  output int unsigned               results_o,
  output int unsigned               early_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tds_pkg::*;

  localparam int unsigned TIPS      = 256;
  localparam int unsigned SLOTS     = 512;

  logic [IDX_W-1:0]  tbl_node  [TIPS];
  logic [IDX_W-1:0]  tbl_left  [TIPS];
  logic [IDX_W-1:0]  tbl_right [TIPS];
  logic [SIZE_W-1:0] size_mem  [SLOTS];
  logic [ONES_W-1:0] ones_mem  [SLOTS];
  int unsigned       entries;
  logic [IDX_W-1:0]  leaf_total;
  tds_out_t          distance_q [$];

  function automatic tds_out_t search_min(tds_in_t w);
    int          p;
    int          total;
    int          half;
    int          best;
    int          d;
    logic [15:0] ones;
    logic [8:0]  node;
    bit          early;
    tds_out_t    r;
    p     = int'(w.light_size);
    total = int'(leaf_total);
    half  = int'(leaf_total) / 2;
    best  = (p > 0) ? p - 1 : 0;
    early = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (i >= int'(w.first_leaf) && i <= int'(w.last_leaf)) begin
        ones_mem[i] = {15'd0, w.side_bit};
      end else begin
        ones_mem[i] = {15'd0, ~w.side_bit};
      end
    end
    for (int i = 0; i < int'(entries); i++) begin
      node = tbl_node[i];
      ones = ones_mem[tbl_left[i]] + ones_mem[tbl_right[i]];
      ones_mem[node] = ones;
      d = p - (int'(size_mem[node]) - int'(ones)) + int'(ones);
      if (d < 0 || d > half) d = total - d;
      if (d >= 0 && d < best) begin
        best = d;
        if (best == 1) begin
          early = 1'b1;
          break;
        end
      end
    end
    r.min_distance  = best[7:0];
    r.stopped_early = early;
    return r;
  endfunction

  task automatic note_fail(string what, string exp_s, string act_s);
    $display("%0t ns: %s mismatch, expected %s, actual %s", $time, what, exp_s, act_s);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tds_out_t exp_r;
    tds_out_t got;
    if (!rst_ni) begin
      entries      = 0;
      leaf_total   = 9'd256;
      fail_count_o = 0;
      results_o    = 0;
      early_o      = 0;
      distance_q.delete();
      pending_o <= 0;
    end else begin
      if (word_out.valid && word_out.ready) begin
        got = word_out.data;
        if (distance_q.size() == 0) begin
          note_fail("unexpected result word", "none",
                    $sformatf("%0d/%0d", got.min_distance, got.stopped_early));
        end else begin
          exp_r = distance_q.pop_front();
          results_o++;
          if (got.stopped_early) early_o++;
          if (got.min_distance !== exp_r.min_distance)
            note_fail("min_distance", $sformatf("%0d", exp_r.min_distance),
                      $sformatf("%0d", got.min_distance));
          if (got.stopped_early !== exp_r.stopped_early)
            note_fail("stopped_early", $sformatf("%0d", exp_r.stopped_early),
                      $sformatf("%0d", got.stopped_early));
        end
      end
      if (word_in.valid && word_in.ready) begin
        case (word_in.data.action)
          ACT_CLEAR: begin
            entries = 0;
          end
          ACT_LOAD: begin
            if (entries < TIPS) begin
              tbl_node[entries]  = word_in.data.node_index;
              tbl_left[entries]  = word_in.data.left_child;
              tbl_right[entries] = word_in.data.right_child;
              size_mem[word_in.data.node_index] = word_in.data.leaves_below;
              entries++;
            end
          end
          ACT_QUERY: begin
            distance_q.push_back(search_min(word_in.data));
          end
          default: ;
        endcase
      end
      if (cfg_we_i) leaf_total = cfg_data_i;
      pending_o <= distance_q.size();
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the transfer distance search testbench: stimulus, flow control and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tds_pkg::*;

  localparam int unsigned MAX_TIPS   = 256;
  localparam int unsigned NODE_SLOTS = 512;
  localparam int unsigned LIMIT      = 5000;
  localparam int unsigned SETTLE     = NODE_SLOTS + 32;
  localparam int unsigned NPH        = 6;
  localparam logic [1:0]  ACT_UNUSED = 2'd3;

  typedef struct {
    int unsigned slot;
    int unsigned lo;
    int unsigned hi;
    int unsigned sz;
  } part_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_data;

  tds_in_if  cmd_if ();
  tds_out_if res_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;
  int unsigned early_stops;

  int unsigned words_sent;
  int unsigned idle_pct;
  int unsigned stall_left;
  int unsigned idle_cnt;
  int unsigned inner_cnt;
  int unsigned tree_leaves;
  int unsigned node_lo [MAX_TIPS];
  int unsigned node_hi [MAX_TIPS];
  int unsigned node_sz [MAX_TIPS];

  transfer_distance_search_top #(
    .MAX_TIPS  (MAX_TIPS),
    .NODE_SLOTS(NODE_SLOTS)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data),
    .in_i      (cmd_if),
    .out_o     (res_if)
  );

  tds_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .word_in     (cmd_if),
    .word_out    (res_if),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results),
    .early_o     (early_stops)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic tds_in_t rand_word();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[64:0];
  endfunction

  function automatic tds_in_t mk(logic [1:0] act, int unsigned node, int unsigned left,
                                 int unsigned right, int unsigned size, int unsigned p,
                                 int unsigned lo, int unsigned hi, bit side);
    tds_in_t w;
    w              = '0;
    w.action       = act;
    w.node_index   = node[8:0];
    w.left_child   = left[8:0];
    w.right_child  = right[8:0];
    w.leaves_below = size[8:0];
    w.light_size   = p[7:0];
    w.first_leaf   = lo[8:0];
    w.last_leaf    = hi[8:0];
    w.side_bit     = side;
    return w;
  endfunction

  // called just after the clock rises; returns once the word has been taken
  task automatic send_word(tds_in_t w);
    int unsigned gap;
    if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      gap = $urandom_range(7, 1);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= w;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // adjacent merges keep every subtree on a contiguous leaf range
  task automatic load_tree(int unsigned n);
    part_t       parts [$];
    part_t       a;
    part_t       b;
    part_t       m;
    int unsigned j;
    tds_in_t     w;
    for (int unsigned l = 0; l < n; l++) parts.push_back('{l, l, l, 1});
    inner_cnt   = 0;
    tree_leaves = n;
    while (parts.size() > 1) begin
      j = $urandom_range(parts.size() - 2, 0);
      a = parts[j];
      b = parts[j + 1];
      m = '{n + inner_cnt, a.lo, b.hi, a.sz + b.sz};
      if ($urandom_range(1, 0) == 1) w = mk(ACT_LOAD, m.slot, a.slot, b.slot, m.sz, 0, 0, 0, 0);
      else w = mk(ACT_LOAD, m.slot, b.slot, a.slot, m.sz, 0, 0, 0, 0);
      send_word(w);
      node_lo[inner_cnt] = m.lo;
      node_hi[inner_cnt] = m.hi;
      node_sz[inner_cnt] = m.sz;
      inner_cnt++;
      parts.delete(j + 1);
      parts[j] = m;
    end
  endtask

  task automatic send_query();
    tds_in_t     w;
    int unsigned sel;
    int unsigned k;
    int unsigned lo;
    int unsigned hi;
    int unsigned a;
    int unsigned b;
    int          pi;
    w        = rand_word();
    w.action = ACT_QUERY;
    sel      = $urandom_range(99, 0);
    if (inner_cnt > 0 && sel < 60) begin
      k  = $urandom_range(inner_cnt - 1, 0);
      lo = node_lo[k];
      hi = node_hi[k];
      case ($urandom_range(3, 0))
        1: if (lo < hi) lo++;
        2: hi++;
        3: if (lo > 0) lo--;
        default: ;
      endcase
      pi = (node_sz[k] * 2 <= tree_leaves) ? int'(node_sz[k]) : int'(tree_leaves - node_sz[k]);
      pi = pi + int'($urandom_range(2, 0)) - 1;
      if (pi < 0) pi = 0;
      w.first_leaf = lo[8:0];
      w.last_leaf  = hi[8:0];
      w.light_size = pi[7:0];
    end else if (sel < 85) begin
      a = $urandom_range(tree_leaves - 1, 0);
      b = $urandom_range(tree_leaves - 1, 0);
      w.first_leaf = (a < b) ? a[8:0] : b[8:0];
      w.last_leaf  = (a < b) ? b[8:0] : a[8:0];
      w.light_size = 8'($urandom_range((tree_leaves > 4) ? tree_leaves / 2 : 2, 2));
    end
    send_word(w);
  endtask

  // receiver back-pressure in bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left   <= 0;
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct / 4) begin
      stall_left   <= $urandom_range(6, 0);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= LIMIT) begin
      $display("timeout: no word moved for %0d cycles", LIMIT);
      $display("transfer_distance_search_top verification failed");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    int unsigned cfg_tab [NPH];
    int unsigned pct_tab [NPH];
    int unsigned phase_end;
    int unsigned kind;
    int unsigned n;
    int unsigned node;
    tds_in_t     w;

    cfg_tab = '{4, 255, $urandom_range(254, 5), 129, 256, 256};
    pct_tab = '{30, 0, 50, 20, 40, 0};
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_data     <= '0;
    cmd_if.valid <= 1'b0;
    cmd_if.data  <= '0;
    words_sent    = 0;
    inner_cnt     = 0;
    tree_leaves   = 4;
    idle_pct      = 25;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, zero p, empty range, unused action, zero distance, early stop
    send_word(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 511, 1));
    send_word(mk(ACT_QUERY, 0, 0, 0, 0, 255, 511, 0, 0));
    w = '1;
    w.action = ACT_UNUSED;
    send_word(w);
    send_word(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk(ACT_LOAD, 4, 0, 1, 2, 0, 0, 0, 0));
    send_word(mk(ACT_LOAD, 5, 3, 2, 2, 0, 0, 0, 0));
    send_word(mk(ACT_LOAD, 6, 4, 5, 4, 0, 0, 0, 0));
    send_word(mk(ACT_QUERY, 0, 0, 0, 0, 2, 0, 1, 0));
    send_word(mk(ACT_QUERY, 0, 0, 0, 0, 3, 0, 1, 0));
    send_word(mk(ACT_QUERY, 0, 0, 0, 0, 2, 0, 3, 1));
    send_word(mk(ACT_LOAD, 511, 511, 0, 511, 0, 0, 0, 0));
    send_word(mk(ACT_LOAD, 0, 0, 511, 0, 0, 0, 0, 0));
    send_word(mk(ACT_QUERY, 0, 0, 0, 0, 128, 0, 0, 1));
    send_word(mk(ACT_QUERY, 0, 0, 0, 0, 1, 2, 3, 0));
    send_word(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk(ACT_QUERY, 0, 0, 0, 0, 2, 0, 3, 1));

    for (int ph = 0; ph < NPH; ph++) begin
      drain();
      cfg_we   <= 1'b1;
      cfg_data <= cfg_tab[ph][8:0];
      @(posedge clk_i);
      cfg_we   <= 1'b0;
      idle_pct  = pct_tab[ph];
      phase_end = words_sent + 150;
      if (ph == 1 || ph == 3) begin
        // full-size tree, then loads beyond a full table
        send_word(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        load_tree(MAX_TIPS);
        repeat ((ph == 1) ? 4 : $urandom_range(4, 2)) begin
          w = rand_word();
          w.action = ACT_LOAD;
          send_word(w);
        end
        repeat (3) send_query();
      end
      while (words_sent < phase_end) begin
        kind = $urandom_range(99, 0);
        if (kind < 70) begin
          if ($urandom_range(9, 0) != 0) send_word(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
          n = ($urandom_range(3, 0) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 4);
          load_tree(n);
          repeat ($urandom_range(6, 1)) send_query();
        end else if (kind < 76) begin
          // self-feeding chain: counts double each entry and may wrap
          node = $urandom_range(NODE_SLOTS - 1, 0);
          send_word(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
          repeat ($urandom_range(20, 14))
            send_word(mk(ACT_LOAD, node, node, node, $urandom_range(511, 0), 0, 0, 0, 0));
          send_word(mk(ACT_QUERY, 0, 0, 0, 0, $urandom_range(255, 0), node, node, 1));
          inner_cnt = 0;
        end else begin
          repeat ($urandom_range(8, 1)) begin
            w = rand_word();
            if ($urandom_range(3, 0) == 0) w.action = ACT_QUERY;
            send_word(w);
          end
        end
      end
    end
    drain();

    $display("Covered %0d command words and %0d distance results, %0d of them stopped early,",
             words_sent, results, early_stops);
    $display("over leaf totals 4 to 256, full-size trees, table overflow and count wrap.");
    if (fail_count == 0) begin
      $display("transfer_distance_search_top verification clean");
    end else begin
      $display("transfer_distance_search_top verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/tds_pkg.sv
hw/rtl/tds_if.sv
hw/rtl/transfer_distance_search_top.sv
tb/sv/tds_checker.sv
tb/sv/testbench.sv
